[src/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, constants and the gesture code table shared by the button gesture
// classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  localparam int unsigned NUM_BUTTONS = 9;
  localparam int unsigned BTN_W       = 4;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CODE_W      = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_MULTI   = 4;
  localparam int unsigned MULTI_W     = 2;

  localparam logic [BTN_W-1:0] FIRST_MULTI = 4'd2;
  localparam logic [BTN_W-1:0] LAST_MULTI  = 4'd5;
  localparam logic [BTN_W-1:0] LAST_BUTTON = 4'd8;
  localparam logic [BTN_W-1:0] NO_BUTTON   = 4'd15;

  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEXT   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LONG   = 3'd6;

  localparam logic [CNT_W-1:0] CNT_ONE = 3'd1;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;
  localparam logic [CNT_W-1:0] CNT_SAT = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_WAIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd3;

  localparam logic [CFG_W-1:0] SINGLE_WAIT_RST = 16'd600;
  localparam logic [CFG_W-1:0] MULTI_WAIT_RST  = 16'd600;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic [BTN_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } dp_status_t;

  function automatic logic [CODE_W-1:0] code_lookup(input logic [BTN_W-1:0] btn,
                                                    input logic [KIND_W-1:0] kind);
    logic [CODE_W-1:0] code;
    logic              single;
    logic              lng;
    begin
      single = (kind == KIND_SINGLE);
      lng    = (kind == KIND_LONG);
      case (btn)
        4'd0:    code = single ? 6'd1  : (lng ? 6'd2  : 6'd0);
        4'd1:    code = single ? 6'd3  : (lng ? 6'd4  : 6'd0);
        4'd2:    code = 6'd5  + {3'b000, kind};
        4'd3:    code = 6'd12 + {3'b000, kind};
        4'd4:    code = 6'd19 + {3'b000, kind};
        4'd5:    code = 6'd26 + {3'b000, kind};
        4'd6:    code = single ? 6'd33 : (lng ? 6'd34 : 6'd0);
        4'd7:    code = single ? 6'd35 : (lng ? 6'd36 : 6'd0);
        4'd8:    code = single ? 6'd37 : (lng ? 6'd38 : 6'd0);
        default: code = 6'd0;
      endcase
      return code;
    end
  endfunction

endpackage

`default_nettype wire

[src/button_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies single, multi and long presses of nine buttons from scans.
// Buttons are walked one per cycle, and a result is registered for the first
// button that shows a gesture; a result held by out_stall also holds the walk.
// A new scan is taken only once the walk of the last one has ended, at a
// gesture or the last button, as all buttons share the classify datapath.
// Reset (rst, synchronous): clears button state, restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [NUM_BUTTONS-1:0] pressed_mask,
  input  wire logic [31:0]            time_ms,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CODE_W-1:0]           press_code,
  output logic [BTN_W-1:0]            button,
  output logic [KIND_W-1:0]           press_kind
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  bgc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pressed_mask (pressed_mask),
    .time_ms      (time_ms),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .press_code   (press_code),
    .button       (button),
    .press_kind   (press_kind)
  );

endmodule

`default_nettype wire

[src/bgc_ctrl.sv]
// ----------------------------------------------------------------------------
// bgc_ctrl
// Scan controller: accepts a scan, then walks the buttons one per cycle, held
// by a stalled output, until a gesture is reported or the last button is done.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_ctrl
  import bgc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output ctrl_cmd_t       cmd,
  input  wire dp_status_t status
);

  state_t           state;
  state_t           state_next;
  logic [BTN_W-1:0] idx;
  logic [BTN_W-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
          idx_next   = '0;
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          if (!status.out_busy) begin
            state_next = ST_IDLE;
          end
        end else if (idx == LAST_BUTTON) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.load = 1'b0;
    cmd.scan = 1'b0;
    cmd.idx  = idx;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/bgc_datapath.sv]
// ----------------------------------------------------------------------------
// bgc_datapath
// Per-button state, configuration registers, the classify step for the
// button selected by the controller, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_datapath
  import bgc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic [NUM_BUTTONS-1:0] pressed_mask,
  input  wire logic [31:0]            time_ms,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CODE_W-1:0]           press_code,
  output logic [BTN_W-1:0]            button,
  output logic [KIND_W-1:0]           press_kind
);

  logic [CFG_W-1:0] single_wait;
  logic [CFG_W-1:0] multi_wait;
  logic [CFG_W-1:0] long_hold;
  logic [CFG_W-1:0] debounce;

  logic [NUM_BUTTONS-1:0] mask_q;
  logic [TIME_BITS-1:0]   now_q;

  logic [NUM_BUTTONS-1:0] held;
  logic [CNT_W-1:0]       taps       [NUM_MULTI];
  logic [TIME_BITS-1:0]   hold_start [NUM_MULTI];
  logic [TIME_BITS-1:0]   last_evt   [NUM_MULTI];
  logic [BTN_W-1:0]       last_btn;

  logic [3:0]           bidx;
  logic [MULTI_W-1:0]   m;
  logic [MULTI_W-1:0]   lm;
  logic                 multi;
  logic                 last_multi;
  logic                 down;
  logic                 held_i;
  logic                 press;
  logic                 release_ev;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] idle;
  logic [TIME_BITS-1:0] wait_t;
  logic                 long_hit;
  logic                 idle_hit;
  logic                 hit;
  logic [KIND_W-1:0]    kind;
  logic [CNT_W-1:0]     sat_cnt;
  logic                 out_busy;
  logic                 commit;

  assign bidx       = cmd.idx;
  assign multi      = bidx inside {[FIRST_MULTI:LAST_MULTI]};
  assign m          = MULTI_W'(bidx - FIRST_MULTI);
  assign last_multi = last_btn inside {[FIRST_MULTI:LAST_MULTI]};
  assign lm         = MULTI_W'(last_btn - FIRST_MULTI);

  always_comb begin
    down       = mask_q[bidx];
    held_i     = held[bidx];
    press      = down && !held_i;
    release_ev = !down && held_i;
    cnt        = taps[m];
    dur        = now_q - hold_start[m];
    idle       = now_q - last_evt[m];
    wait_t     = (cnt == CNT_ONE) ? TIME_BITS'(single_wait) : TIME_BITS'(multi_wait);
    long_hit   = release_ev && multi && (dur >= TIME_BITS'(long_hold));
    idle_hit   = multi && !down && !held_i && (cnt != '0) && (idle > wait_t);
    hit        = (press && !multi) || long_hit || idle_hit;
    sat_cnt    = (cnt >= CNT_SAT) ? CNT_SAT : cnt;
    if (long_hit) begin
      kind = KIND_LONG;
    end else if (idle_hit) begin
      kind = KIND_W'(sat_cnt - CNT_ONE);
    end else begin
      kind = KIND_SINGLE;
    end
  end

  assign out_busy        = out_valid && out_stall;
  assign commit          = cmd.scan && !(hit && out_busy);
  assign status.hit      = cmd.scan && hit;
  assign status.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_wait <= SINGLE_WAIT_RST;
      multi_wait  <= MULTI_WAIT_RST;
      long_hold   <= LONG_HOLD_RST;
      debounce    <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SINGLE_WAIT: single_wait <= cfg_data;
        REG_MULTI_WAIT:  multi_wait  <= cfg_data;
        REG_LONG_HOLD:   long_hold   <= cfg_data;
        REG_DEBOUNCE:    debounce    <= cfg_data;
        default:         single_wait <= single_wait;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_q <= pressed_mask;
      now_q  <= TIME_BITS'(time_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      last_btn <= NO_BUTTON;
      for (int i = 0; i < NUM_MULTI; i++) begin
        taps[i]       <= '0;
        hold_start[i] <= '0;
        last_evt[i]   <= '0;
      end
    end else if (commit) begin
      if (press) begin
        if ((last_btn != bidx) && last_multi) begin
          taps[lm] <= '0;
        end
        held[bidx] <= 1'b1;
        last_btn   <= bidx;
        if (multi) begin
          hold_start[m] <= now_q;
          last_evt[m]   <= now_q;
        end
      end else if (release_ev) begin
        held[bidx] <= 1'b0;
        if (multi && !long_hit) begin
          if ((dur > TIME_BITS'(debounce)) && (cnt < CNT_MAX)) begin
            taps[m] <= cnt + CNT_ONE;
          end
          last_evt[m] <= now_q;
        end
      end else if (idle_hit) begin
        taps[m] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && hit) begin
      press_code <= code_lookup(bidx, kind);
      button     <= bidx;
      press_kind <= kind;
    end
  end

endmodule

`default_nettype wire

[sim/tb_button_gesture_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Self-checking bench for the button gesture classifier. A queue of scans,
// directed corner cases first and then random tap, hold and noise sequences,
// feeds a bursty driver; a scoreboard predicts each gesture from its own
// model of the button state and checks every result against it. The timing
// registers are reloaded between phases, including their extreme values.
// ----------------------------------------------------------------------------

module tb_button_gesture_classifier;
  import bgc_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_LEN   = 500;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] mask;
    logic [31:0]            stamp;
  } scan_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BTN_W-1:0]  btn;
    logic [KIND_W-1:0] kind;
  } gesture_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [NUM_BUTTONS-1:0] pressed_mask = '0;
  logic [31:0]            time_ms = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CODE_W-1:0]      press_code;
  logic [BTN_W-1:0]       button;
  logic [KIND_W-1:0]      press_kind;

  button_gesture_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pressed_mask (pressed_mask),
    .time_ms      (time_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .press_code   (press_code),
    .button       (button),
    .press_kind   (press_kind)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timing registers as the block holds them
  logic [CFG_W-1:0] cfg_single   = SINGLE_WAIT_RST;
  logic [CFG_W-1:0] cfg_multi    = MULTI_WAIT_RST;
  logic [CFG_W-1:0] cfg_long     = LONG_HOLD_RST;
  logic [CFG_W-1:0] cfg_debounce = DEBOUNCE_RST;

  // Button state
  logic [NUM_BUTTONS-1:0] held = '0;
  logic [CNT_W-1:0]       taps     [NUM_MULTI] = '{default: '0};
  logic [31:0]            press_ms [NUM_MULTI] = '{default: '0};
  logic [31:0]            event_ms [NUM_MULTI] = '{default: '0};
  logic [BTN_W-1:0]       last_btn = NO_BUTTON;

  scan_item_t  pending_scans[$];
  gesture_t    expected_gestures[$];
  logic [31:0] scan_clock = '0;

  int unsigned errors = 0;
  int unsigned gestures_seen = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_off = 0;
  bit          hold_off_done = 1'b0;
  logic [31:0] rx_cycles = '0;
  int unsigned quiet_cycles = 0;

  function automatic gesture_t make_gesture(int b, logic [KIND_W-1:0] kind);
    gesture_t g;
    logic [CODE_W-1:0] base;
    case (b)
      0: base = 6'd1;
      1: base = 6'd3;
      2: base = 6'd5;
      3: base = 6'd12;
      4: base = 6'd19;
      5: base = 6'd26;
      6: base = 6'd33;
      7: base = 6'd35;
      default: base = 6'd37;
    endcase
    if (b >= FIRST_MULTI && b <= LAST_MULTI)
      g.code = base + CODE_W'(kind);
    else
      g.code = base + ((kind == KIND_LONG) ? 6'd1 : 6'd0);
    g.btn  = BTN_W'(b);
    g.kind = kind;
    return g;
  endfunction

  function automatic bit classify_scan(input logic [NUM_BUTTONS-1:0] mask,
                                       input logic [31:0] now, output gesture_t g);
    logic [31:0]      span;
    logic [31:0]      limit;
    logic [CNT_W-1:0] n;
    bit               multi;
    int               m;
    g = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      multi = (b >= FIRST_MULTI) && (b <= LAST_MULTI);
      m = multi ? b - FIRST_MULTI : 0;
      if (mask[b] && !held[b]) begin
        // a different button going down drops the previous tap count
        if (last_btn != b && last_btn >= FIRST_MULTI && last_btn <= LAST_MULTI)
          taps[last_btn - FIRST_MULTI] = '0;
        held[b] = 1'b1;
        last_btn = BTN_W'(b);
        if (!multi) begin
          g = make_gesture(b, KIND_SINGLE);
          return 1'b1;
        end
        press_ms[m] = now;
        event_ms[m] = now;
      end else if (!mask[b] && held[b]) begin
        held[b] = 1'b0;
        if (multi) begin
          span = now - press_ms[m];
          if (span >= {16'd0, cfg_long}) begin
            g = make_gesture(b, KIND_LONG);
            return 1'b1;
          end
          if (span > {16'd0, cfg_debounce} && taps[m] < CNT_MAX)
            taps[m] = taps[m] + 1'b1;
          event_ms[m] = now;
        end
      end
      if (multi && !held[b] && taps[m] != '0) begin
        span = now - event_ms[m];
        limit = (taps[m] == CNT_ONE) ? {16'd0, cfg_single} : {16'd0, cfg_multi};
        if (span > limit) begin
          n = (taps[m] >= CNT_SAT) ? CNT_SAT : taps[m];
          taps[m] = '0;
          g = make_gesture(b, KIND_W'(n - 1'b1));
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_scan(logic [NUM_BUTTONS-1:0] mask, logic [31:0] dt);
    scan_item_t it;
    scan_clock = scan_clock + dt;
    it.mask  = mask;
    it.stamp = scan_clock;
    pending_scans.push_back(it);
  endfunction

  // Noise scans, or taps, holds and idles on one button sized to current timing
  function automatic void queue_gesture();
    int unsigned b, presses, hold, gap, lim, short_wait;
    logic [NUM_BUTTONS-1:0] pm;
    if ($urandom_range(0, 5) == 0) begin
      push_scan(NUM_BUTTONS'($urandom_range(0, 511)), $urandom_range(0, 3000));
      push_scan('0, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2000));
      return;
    end
    if ($urandom_range(0, 9) < 7) begin
      b = $urandom_range(2, 5);
    end else begin
      b = $urandom_range(0, 4);
      if (b >= 2) b = b + 4;
    end
    pm = '0;
    pm[b] = 1'b1;
    presses = $urandom_range(1, 8);
    lim = (presses == 1) ? cfg_single : cfg_multi;
    short_wait = (cfg_single < cfg_multi) ? cfg_single : cfg_multi;
    for (int i = 0; i < presses; i++) begin
      case ($urandom_range(0, 6))
        0: hold = 0;
        1: hold = cfg_debounce;
        2: hold = cfg_debounce + 1;
        3: hold = cfg_long - 1;
        4: hold = cfg_long;
        5: hold = cfg_long + $urandom_range(0, 500);
        default: hold = $urandom_range(0, 2000);
      endcase
      gap = ($urandom_range(0, 4) != 0) ? $urandom_range(0, short_wait)
                                         : $urandom_range(0, lim + 100);
      push_scan(pm, gap);
      if ($urandom_range(0, 2) == 0) begin
        push_scan(pm, hold / 2);
        push_scan('0, hold - hold / 2);
      end else begin
        push_scan('0, hold);
      end
    end
    if ($urandom_range(0, 1) == 0)
      push_scan('0, lim);
    push_scan('0, lim + $urandom_range(1, 300));
  endfunction

  function automatic void queue_random(int unsigned count);
    int unsigned target;
    target = pending_scans.size() + count;
    scan_clock = $urandom;
    while (pending_scans.size() < target)
      queue_gesture();
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (pending_scans.size() != 0 || in_valid || expected_gestures.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_timing(logic [CFG_W-1:0] single_w, logic [CFG_W-1:0] multi_w,
                             logic [CFG_W-1:0] long_h, logic [CFG_W-1:0] deb);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SINGLE_WAIT;
    cfg_data  <= single_w;
    @(posedge clk);
    cfg_index <= REG_MULTI_WAIT;
    cfg_data  <= multi_w;
    @(posedge clk);
    cfg_index <= REG_LONG_HOLD;
    cfg_data  <= long_h;
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_single   = single_w;
    cfg_multi    = multi_w;
    cfg_long     = long_h;
    cfg_debounce = deb;
    @(negedge clk);
  endtask

  // Driver: bursts of scans with random gaps
  always @(posedge clk) begin : sender
    scan_item_t nxt;
    gesture_t   g;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (classify_scan(pressed_mask, time_ms, g))
          expected_gestures.push_back(g);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_scans.size() != 0) begin
          nxt = pending_scans.pop_front();
          pressed_mask <= nxt.mask;
          time_ms      <= nxt.stamp;
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1'b1;
      if (!hold_off_done && gestures_seen >= 4) begin
        hold_off = HOLD_OFF_LEN;
        hold_off_done = 1'b1;
      end
      if (hold_off != 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else begin
        case (rx_cycles[9:8])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 1) == 0);
          2'd2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Monitor and scoreboard
  always @(posedge clk) begin : monitor
    gesture_t actual;
    gesture_t want;
    if (!rst && out_valid && !out_stall) begin
      actual = {press_code, button, press_kind};
      gestures_seen++;
      if (expected_gestures.size() == 0) begin
        $display("%0t: unexpected transaction: code %0d button %0d kind %0d",
                 $time, press_code, button, press_kind);
        errors++;
      end else begin
        want = expected_gestures.pop_front();
        if (actual != want) begin
          $display("%0t: mismatch: expected code %0d button %0d kind %0d, actual code %0d button %0d kind %0d",
                   $time, want.code, want.btn, want.kind, press_code, button, press_kind);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // button 0 alone, then all nine down and released after a long hold
    push_scan(9'h001, 100);
    push_scan(9'h000, 10);
    push_scan(9'h1FF, 90);
    repeat (4) push_scan(9'h1FF, 10);
    push_scan(9'h000, 1260);
    repeat (4) push_scan(9'h000, 10);
    // double tap on button 2
    push_scan(9'h004, 1460);
    push_scan(9'h000, 100);
    push_scan(9'h004, 100);
    push_scan(9'h000, 100);
    push_scan(9'h000, 700);
    // release too short to count on button 4
    push_scan(9'h010, 1000);
    push_scan(9'h000, 20);
    push_scan(9'h000, 1000);
    // tap on button 3 dropped by a press of button 4
    push_scan(9'h008, 1000);
    push_scan(9'h000, 100);
    push_scan(9'h010, 100);
    push_scan(9'h000, 100);
    push_scan(9'h000, 700);
    // hold across the timestamp wrap on button 5
    push_scan(9'h020, 32'hFFFF_FF00 - scan_clock);
    push_scan(9'h000, 32'h0000_0200);
    push_scan(9'h000, 700);

    queue_random(100);
    settle();
    load_timing(16'd0, 16'd0, 16'hFFFF, 16'd0);
    queue_random(105);
    settle();
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100);
    queue_random(105);
    settle();
    load_timing(16'd50, 16'd200, 16'd300, 16'd0);
    queue_random(105);
    settle();
    load_timing(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    queue_random(105);
    settle();
    load_timing(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 2000)),
                CFG_W'($urandom_range(100, 5000)), CFG_W'($urandom_range(0, 99)));
    queue_random(105);
    settle();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
src/bgc_pkg.sv
src/bgc_ctrl.sv
src/bgc_datapath.sv
src/button_gesture_classifier.sv
sim/tb_button_gesture_classifier.sv
